### rtl/core/particle_slab_grid_deposit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slab grid deposit block
// Clocked property wrappers that report failures with $error.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_SLAB_GRID_DEPOSIT_MACROS_SVH
`define PARTICLE_SLAB_GRID_DEPOSIT_MACROS_SVH

// Property checked at every rising edge outside of reset.
`define PSGD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property checked at every rising edge, reset included.
`define PSGD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/psgd_pkg.sv
// ----------------------------------------------------------------------------
// Slab grid deposit package
// Sizes, codes, transaction types and helper functions shared by the block.
// ----------------------------------------------------------------------------
package psgd_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned PLANE_RES  = 256;
  localparam int unsigned BIN_BITS   = $clog2(PLANE_RES);
  localparam int unsigned DEPTH      = PLANE_RES * PLANE_RES;
  localparam int unsigned ADDR_BITS  = $clog2(DEPTH);
  localparam int unsigned PROD_W     = COORD_BITS + $clog2(PLANE_RES + 1);
  localparam int unsigned CELL_W     = 32;
  localparam int unsigned TOTAL_W    = 48;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CFG_DW     = 64;
  localparam int unsigned CFG_AW     = 6;

  typedef enum logic [1:0] {
    OP_DEPOSIT    = 2'd0,
    OP_READ_CELL  = 2'd1,
    OP_READ_TOTAL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    REG_OFFSET_X    = 3'd0,
    REG_OFFSET_Y    = 3'd1,
    REG_OFFSET_Z    = 3'd2,
    REG_NORMAL_AXIS = 3'd3,
    REG_CORNER_ROW  = 3'd4,
    REG_CORNER_COL  = 3'd5,
    REG_SLAB_LOW    = 3'd6,
    REG_SLAB_HIGH   = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIN,
    ST_READ,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [1:0]            operation;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] pos_z;
    logic [IDX_W-1:0]      cell_row;
    logic [IDX_W-1:0]      cell_col;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_count;
    logic [TOTAL_W-1:0] plane_total;
    logic               landed;
  } out_item_t;

  // Removes the offset and wraps into (0, box]; box itself is 2^COORD_BITS.
  function automatic logic [COORD_BITS:0] wrap_coord(input logic [COORD_BITS-1:0] pos,
                                                     input logic [COORD_BITS-1:0] off);
    logic [COORD_BITS-1:0] d;
    d = pos - off;
    return (d == '0) ? {1'b1, {COORD_BITS{1'b0}}} : {1'b0, d};
  endfunction

endpackage

### rtl/core/psgd_in_if.sv
// ----------------------------------------------------------------------------
// Slab grid deposit input channel
// Valid/ready channel that carries one particle or read request.
// ----------------------------------------------------------------------------
interface psgd_in_if;
  import psgd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/psgd_out_if.sv
// ----------------------------------------------------------------------------
// Slab grid deposit output channel
// Valid/ready channel that carries one result.
// ----------------------------------------------------------------------------
interface psgd_out_if;
  import psgd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/psgd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module psgd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/particle_slab_grid_deposit.sv
// ----------------------------------------------------------------------------
// Particle slab grid deposit
// Nearest-grid-point particle counter projected through one slab.
// ----------------------------------------------------------------------------
// Each transaction passes through the core in order: capture with periodic
// wrap, slab test and bin index, count memory read, then read-modify-write of
// the cell and loading of the result register; the single-read-port count
// memory and its read-modify-write order set this sequence. A new transaction is
// accepted in the cycle after write-back even while the result still waits; if
// the result register is still full at write-back, the core waits for it.
// After reset the core sweeps the count memory to zero, one cell per cycle,
// over all PLANE_RES * PLANE_RES = 65536 cells, and accepts no transaction until
// then. Register i sits at byte address 8*i of the APB port.
module particle_slab_grid_deposit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psgd_pkg::CFG_AW-1:0]   paddr,
  input  logic [psgd_pkg::CFG_DW-1:0]   pwdata,
  output logic [psgd_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  psgd_in_if.sink                       in_i,
  psgd_out_if.source                    out_o
);
  import psgd_pkg::*;

  state_e                state_q, state_d;
  in_item_t              item_q;
  logic [COORD_BITS:0]   x_q, y_q, z_q;
  logic [ADDR_BITS-1:0]  addr_q, addr_d;
  logic [ADDR_BITS-1:0]  clr_q;
  logic                  hit_q, hit_d;
  logic [TOTAL_W-1:0]    total_q, total_d;
  out_item_t             out_q, out_d;
  logic                  out_valid_q;

  logic [COORD_BITS-1:0] offset_x_q, offset_y_q, offset_z_q;
  logic [1:0]            normal_axis_q;
  logic [COORD_BITS-1:0] corner_row_q, corner_col_q;
  logic [COORD_BITS:0]   slab_low_q, slab_high_q;

  cfg_reg_e              cfg_idx;
  logic                  cfg_we;

  logic                  in_acc;
  logic                  out_load;
  logic                  ram_we, ram_re;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [CELL_W-1:0]     ram_wdata, ram_rdata;
  logic                  upd_we;
  logic [CELL_W-1:0]     upd_data;

  logic [COORD_BITS:0]   nv, rv, cv;
  logic [COORD_BITS:0]   row_rel, col_rel;
  logic [PROD_W-1:0]     row_prod, col_prod;
  logic [BIN_BITS-1:0]   row_bin, col_bin;
  logic                  row_ok, col_ok, slab_ok, rd_ok;
  logic [ADDR_BITS-1:0]  dep_addr, rd_addr;
  logic [CELL_W-1:0]     cnt_inc;
  logic [TOTAL_W-1:0]    tot_inc;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_e'(paddr[CFG_AW-1:3]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q    <= '0;
      offset_y_q    <= '0;
      offset_z_q    <= '0;
      normal_axis_q <= AXIS_Z;
      corner_row_q  <= '0;
      corner_col_q  <= '0;
      slab_low_q    <= '0;
      slab_high_q   <= {1'b1, {COORD_BITS{1'b0}}};
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OFFSET_X:    offset_x_q    <= pwdata[COORD_BITS-1:0];
        REG_OFFSET_Y:    offset_y_q    <= pwdata[COORD_BITS-1:0];
        REG_OFFSET_Z:    offset_z_q    <= pwdata[COORD_BITS-1:0];
        REG_NORMAL_AXIS: normal_axis_q <= pwdata[1:0];
        REG_CORNER_ROW:  corner_row_q  <= pwdata[COORD_BITS-1:0];
        REG_CORNER_COL:  corner_col_q  <= pwdata[COORD_BITS-1:0];
        REG_SLAB_LOW:    slab_low_q    <= pwdata[COORD_BITS:0];
        REG_SLAB_HIGH:   slab_high_q   <= pwdata[COORD_BITS:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_OFFSET_X:    prdata = CFG_DW'(offset_x_q);
      REG_OFFSET_Y:    prdata = CFG_DW'(offset_y_q);
      REG_OFFSET_Z:    prdata = CFG_DW'(offset_z_q);
      REG_NORMAL_AXIS: prdata = CFG_DW'(normal_axis_q);
      REG_CORNER_ROW:  prdata = CFG_DW'(corner_row_q);
      REG_CORNER_COL:  prdata = CFG_DW'(corner_col_q);
      REG_SLAB_LOW:    prdata = CFG_DW'(slab_low_q);
      REG_SLAB_HIGH:   prdata = CFG_DW'(slab_high_q);
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == ADDR_BITS'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_BIN;
        end
      end
      ST_BIN:  state_d = ST_READ;
      ST_READ: state_d = ST_WRITE;
      ST_WRITE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_i.ready = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = upd_data;
    out_load   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE:  in_i.ready = 1'b1;
      ST_BIN:   ;
      ST_READ:  ram_re = 1'b1;
      ST_WRITE: begin
        out_load = !out_valid_q || out_o.ready;
        ram_we   = out_load && upd_we;
      end
      default: ;
    endcase
  end

  assign in_acc = in_i.valid && in_i.ready;

  // Slab test and bin index.
  always_comb begin
    nv = z_q;
    rv = x_q;
    cv = y_q;
    case (normal_axis_q)
      AXIS_X: begin
        nv = x_q;
        rv = y_q;
        cv = z_q;
      end
      AXIS_Y: begin
        nv = y_q;
        rv = x_q;
        cv = z_q;
      end
      default: ;
    endcase
  end

  assign slab_ok  = (nv >= slab_low_q) && (nv < slab_high_q);
  assign row_rel  = rv - {1'b0, corner_row_q};
  assign col_rel  = cv - {1'b0, corner_col_q};
  assign row_ok   = (rv >= {1'b0, corner_row_q}) && !row_rel[COORD_BITS];
  assign col_ok   = (cv >= {1'b0, corner_col_q}) && !col_rel[COORD_BITS];
  assign row_prod = PROD_W'(row_rel[COORD_BITS-1:0]) * PROD_W'(PLANE_RES);
  assign col_prod = PROD_W'(col_rel[COORD_BITS-1:0]) * PROD_W'(PLANE_RES);
  assign row_bin  = row_prod[COORD_BITS +: BIN_BITS];
  assign col_bin  = col_prod[COORD_BITS +: BIN_BITS];
  assign dep_addr = ADDR_BITS'(row_bin) * ADDR_BITS'(PLANE_RES) + ADDR_BITS'(col_bin);
  assign rd_ok    = (32'(item_q.cell_row) < PLANE_RES) && (32'(item_q.cell_col) < PLANE_RES);
  assign rd_addr  = ADDR_BITS'(item_q.cell_row) * ADDR_BITS'(PLANE_RES)
                  + ADDR_BITS'(item_q.cell_col);

  always_comb begin
    hit_d  = 1'b0;
    addr_d = dep_addr;
    case (item_q.operation)
      OP_DEPOSIT:   hit_d = slab_ok && row_ok && col_ok;
      OP_READ_CELL: begin
        hit_d  = rd_ok;
        addr_d = rd_addr;
      end
      default: ;
    endcase
  end

  // Read-modify-write of the cell and the plane total.
  assign cnt_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + CELL_W'(1);
  assign tot_inc = (total_q == '1) ? total_q : total_q + TOTAL_W'(1);

  always_comb begin
    out_d    = '0;
    total_d  = total_q;
    upd_we   = 1'b0;
    upd_data = '0;
    case (item_q.operation)
      OP_DEPOSIT: begin
        out_d.plane_total = total_q;
        if (hit_q) begin
          upd_we            = 1'b1;
          upd_data          = cnt_inc;
          total_d           = tot_inc;
          out_d.cell_count  = cnt_inc;
          out_d.plane_total = tot_inc;
          out_d.landed      = 1'b1;
        end
      end
      OP_READ_CELL: begin
        out_d.plane_total = total_q;
        if (hit_q) begin
          upd_we           = 1'b1;
          out_d.cell_count = ram_rdata;
        end
      end
      OP_READ_TOTAL: begin
        out_d.plane_total = total_q;
        total_d           = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_BITS'(1);
      end
      if (out_load) begin
        total_q <= total_d;
      end
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_i.data;
      x_q    <= wrap_coord(in_i.data.pos_x, offset_x_q);
      y_q    <= wrap_coord(in_i.data.pos_y, offset_y_q);
      z_q    <= wrap_coord(in_i.data.pos_z, offset_z_q);
    end
    if (state_q == ST_BIN) begin
      hit_q  <= hit_d;
      addr_q <= addr_d;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  psgd_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

### rtl/core/psgd_checker.sv
// ----------------------------------------------------------------------------
// Slab grid deposit checker
// Port-level assertions on the channels of the deposit block.
// ----------------------------------------------------------------------------
`include "particle_slab_grid_deposit_macros.svh"

module psgd_checker (
  input logic                val_clk_i,
  input logic                val_rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input psgd_pkg::out_item_t out_data_i
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // The core works on one transaction at a time.
  `PSGD_ASSERT(a_one_in_flight, val_clk_i, val_rst_ni, in_acc |=> !in_ready_i, "transaction accepted while busy")

  // A landed particle always leaves a nonzero cell count and plane total.
  `PSGD_ASSERT(a_landed_counts, val_clk_i, val_rst_ni, (out_valid_i && out_data_i.landed) |-> ((out_data_i.cell_count != '0) && (out_data_i.plane_total != '0)), "landed result with zero count")

  `PSGD_ASSERT(a_out_hold, val_clk_i, val_rst_ni, out_stall |=> out_valid_i, "result dropped while stalled")

  `PSGD_ASSERT(a_out_stable, val_clk_i, val_rst_ni, out_stall |=> $stable(out_data_i), "result changed while stalled")

  // No result may appear while reset is applied.
  `PSGD_ASSERT_ALWAYS(a_reset_quiet, val_clk_i, !val_rst_ni |-> !out_valid_i, "result valid during reset")

endmodule

bind particle_slab_grid_deposit psgd_checker u_psgd_checker (
  .val_clk_i   (clk_i),
  .val_rst_ni  (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
